@@ rtl/akdp_pkg.sv @@
// Shared types and constants for the attention key dot-product core.
// No dependencies; imported by attention_key_dot_product_core.
package akdp_pkg;

  // Datapath geometry
  localparam int LANES        = 8;
  localparam int MAX_HEAD_DIM = 128;
  localparam int MAX_KEYS     = 4096;
  localparam int ELEM_W       = 16;
  localparam int PROD_W       = 2 * ELEM_W;
  localparam int ACC_W        = 40;
  localparam int SUM_W        = PROD_W + $clog2(LANES);
  localparam int CHUNKS       = MAX_HEAD_DIM / LANES;
  localparam int CHUNK_AW     = $clog2(CHUNKS);
  localparam int POS_W        = 5;
  localparam int IDX_W        = 12;
  localparam int NUM_KEYS_W   = 13;
  localparam int HEAD_DIM_W   = 8;
  localparam int CFG_DATA_W   = 13;
  localparam int LANE_SHIFT   = $clog2(LANES);

  // Result queue
  localparam int FIFO_DEPTH   = 8;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW      = FIFO_AW + 1;

  // Register indexes
  typedef enum logic [0:0] {
    REG_HEAD_DIM = 1'b0,
    REG_NUM_KEYS = 1'b1
  } reg_index_t;

  // Operation codes
  typedef enum logic [0:0] {
    OP_QUERY = 1'b0,
    OP_KEY   = 1'b1
  } op_t;

  // Per-transaction control that travels with a key chunk
  typedef struct packed {
    logic             fresh;     // accumulate from zero
    logic             end_row;   // last chunk of the key row
    logic [IDX_W-1:0] key_index;
    logic             last;
  } key_ctrl_t;

endpackage

@@ rtl/attention_key_dot_product_core.sv @@
// Attention key dot-product core: one stored query vector against a stream of keys.
// Depends on akdp_pkg and akdp_ram (query chunk store).
//
// Usage:
//   Input channel (in_valid/in_stall) carries op plus eight Q4.12 lanes.
//   op 0 writes a query chunk at the current chunk position and restarts the
//   key run; op 1 multiplies a key chunk with the stored query chunk and
//   accumulates. After head_dim/8 key chunks one logit (Q16.24) leaves on the
//   output channel (out_valid/out_stall) with its key index and a last-key flag.
//   Configuration: cfg_write/cfg_index/cfg_data write head_dim (index 0) and
//   num_keys (index 1); write them only while no transaction is in flight.
//   Throughput: one transaction per cycle while in_stall is low, set by the query
//   store having one read and one write port, each used once per transaction.
//   Result path: after the edge that accepts the final key chunk of its row, a
//   logit passes RAM read, multiply, two adder-tree stages and accumulate into
//   the result queue before it is presented.
//   Stall: results wait in an eight-entry queue; the input stalls only while
//   eight results are queued or in flight.
//   Reset: counters, accumulator and queue clear; head_dim = 128, num_keys = 64.
//   The query store is not cleared and must be loaded before keys stream.
module attention_key_dot_product_core
  import akdp_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_write,
  input  logic                         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         op,
  input  logic signed [ELEM_W-1:0]     lane0,
  input  logic signed [ELEM_W-1:0]     lane1,
  input  logic signed [ELEM_W-1:0]     lane2,
  input  logic signed [ELEM_W-1:0]     lane3,
  input  logic signed [ELEM_W-1:0]     lane4,
  input  logic signed [ELEM_W-1:0]     lane5,
  input  logic signed [ELEM_W-1:0]     lane6,
  input  logic signed [ELEM_W-1:0]     lane7,
  // output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [ACC_W-1:0]      logit,
  output logic [IDX_W-1:0]             key_index,
  output logic                         last_key
);

  // Configuration registers
  logic [HEAD_DIM_W-1:0] head_dim;
  logic [NUM_KEYS_W-1:0] num_keys;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_dim <= HEAD_DIM_W'(MAX_HEAD_DIM);
      num_keys <= NUM_KEYS_W'(64);
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_HEAD_DIM: head_dim <= cfg_data[HEAD_DIM_W-1:0];
        REG_NUM_KEYS: num_keys <= cfg_data[NUM_KEYS_W-1:0];
        default:      ;
      endcase
    end
  end

  // Effective row length in chunks and last key index
  logic [POS_W-1:0] chunks;
  logic [IDX_W-1:0] key_lim;

  always_comb begin
    chunks = POS_W'(head_dim >> LANE_SHIFT);
    if (chunks == '0) begin
      chunks = POS_W'(1);
    end else if (chunks > POS_W'(CHUNKS)) begin
      chunks = POS_W'(CHUNKS);
    end
    if (num_keys <= NUM_KEYS_W'(1)) begin
      key_lim = '0;
    end else if (num_keys > NUM_KEYS_W'(MAX_KEYS)) begin
      key_lim = IDX_W'(MAX_KEYS - 1);
    end else begin
      key_lim = IDX_W'(num_keys - NUM_KEYS_W'(1));
    end
  end

  // Input gather
  logic signed [ELEM_W-1:0] in_lane [LANES];
  assign in_lane[0] = lane0;
  assign in_lane[1] = lane1;
  assign in_lane[2] = lane2;
  assign in_lane[3] = lane3;
  assign in_lane[4] = lane4;
  assign in_lane[5] = lane5;
  assign in_lane[6] = lane6;
  assign in_lane[7] = lane7;

  // Sequencing state
  logic [POS_W-1:0]   chunk_position, chunk_position_next;
  logic [IDX_W-1:0]   key_counter, key_counter_next;
  logic               acc_dirty, acc_dirty_next;
  logic [FIFO_CW-1:0] pending, pending_next;

  logic               in_acc, out_acc;
  logic               is_key;
  logic [POS_W-1:0]   pos, pos_inc;
  logic               row_done, key_last;
  key_ctrl_t          in_ctrl;

  assign in_stall = (pending >= FIFO_CW'(FIFO_DEPTH));
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign is_key   = (op_t'(op) == OP_KEY);

  // Position, row end and key counting for the accepted transaction
  always_comb begin
    pos       = (chunk_position >= chunks) ? '0 : chunk_position;
    pos_inc   = pos + POS_W'(1);
    row_done  = (pos_inc >= chunks);
    key_last  = (key_counter >= key_lim);

    in_ctrl.fresh     = !acc_dirty;
    in_ctrl.end_row   = row_done;
    in_ctrl.key_index = key_counter;
    in_ctrl.last      = key_last;

    chunk_position_next = chunk_position;
    key_counter_next    = key_counter;
    acc_dirty_next      = acc_dirty;
    if (in_acc) begin
      chunk_position_next = row_done ? '0 : pos_inc;
      if (!is_key) begin
        key_counter_next = '0;
        acc_dirty_next   = 1'b0;
      end else if (row_done) begin
        key_counter_next = key_last ? '0 : key_counter + IDX_W'(1);
        acc_dirty_next   = 1'b0;
      end else begin
        acc_dirty_next   = 1'b1;
      end
    end

    pending_next = pending;
    if (in_acc && is_key && row_done) begin
      pending_next = pending_next + FIFO_CW'(1);
    end
    if (out_acc) begin
      pending_next = pending_next - FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_position <= '0;
      key_counter    <= '0;
      acc_dirty      <= 1'b0;
      pending        <= '0;
    end else begin
      chunk_position <= chunk_position_next;
      key_counter    <= key_counter_next;
      acc_dirty      <= acc_dirty_next;
      pending        <= pending_next;
    end
  end

  // Query store: one row of LANES elements per chunk
  logic [LANES*ELEM_W-1:0] q_wdata, q_rdata;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      q_wdata[i*ELEM_W +: ELEM_W] = in_lane[i];
    end
  end

  akdp_ram #(
    .WIDTH(LANES*ELEM_W),
    .DEPTH(CHUNKS)
  ) u_query_ram (
    .clk    (clk),
    .wr_en  (in_acc && !is_key),
    .wr_addr(pos[CHUNK_AW-1:0]),
    .wr_data(q_wdata),
    .rd_en  (in_acc && is_key),
    .rd_addr(pos[CHUNK_AW-1:0]),
    .rd_data(q_rdata)
  );

  // Stage 1: key lanes wait alongside the RAM read
  logic                     s1_valid;
  key_ctrl_t                s1_ctrl;
  logic signed [ELEM_W-1:0] s1_key [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_acc && is_key;
    end
  end

  always_ff @(posedge clk) begin
    s1_ctrl <= in_ctrl;
    s1_key  <= in_lane;
  end

  // Stage 2: lane products
  logic                     s2_valid;
  key_ctrl_t                s2_ctrl;
  logic signed [PROD_W-1:0] s2_prod [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_ctrl <= s1_ctrl;
    for (int i = 0; i < LANES; i++) begin
      s2_prod[i] <= s1_key[i] * $signed(q_rdata[i*ELEM_W +: ELEM_W]);
    end
  end

  // Stage 3: sum each half of the lanes
  logic                    s3_valid;
  key_ctrl_t               s3_ctrl;
  logic signed [SUM_W-1:0] s3_half [2];
  logic signed [SUM_W-1:0] half_sum [2];

  always_comb begin
    for (int h = 0; h < 2; h++) begin
      half_sum[h] = '0;
      for (int i = 0; i < LANES / 2; i++) begin
        half_sum[h] = half_sum[h] + SUM_W'(s2_prod[h*(LANES/2) + i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_ctrl <= s2_ctrl;
    s3_half <= half_sum;
  end

  // Stage 4: chunk sum
  logic                    s4_valid;
  key_ctrl_t               s4_ctrl;
  logic signed [SUM_W-1:0] s4_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s4_ctrl <= s3_ctrl;
    s4_sum  <= s3_half[0] + s3_half[1];
  end

  // Accumulate; a finished row goes to the result queue
  logic signed [ACC_W-1:0] accumulator;
  logic signed [ACC_W-1:0] acc_sum;
  logic                    fifo_push;

  assign acc_sum   = (s4_ctrl.fresh ? '0 : accumulator) + ACC_W'(s4_sum);
  assign fifo_push = s4_valid && s4_ctrl.end_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
    end else if (s4_valid) begin
      accumulator <= s4_ctrl.end_row ? '0 : acc_sum;
    end
  end

  // Result queue
  logic signed [ACC_W-1:0] fifo_logit [FIFO_DEPTH];
  logic [IDX_W-1:0]        fifo_idx   [FIFO_DEPTH];
  logic                    fifo_last  [FIFO_DEPTH];
  logic [FIFO_AW-1:0]      wr_ptr, rd_ptr;
  logic [FIFO_CW-1:0]      fifo_count;

  always_ff @(posedge clk) begin
    if (fifo_push) begin
      fifo_logit[wr_ptr] <= acc_sum;
      fifo_idx[wr_ptr]   <= s4_ctrl.key_index;
      fifo_last[wr_ptr]  <= s4_ctrl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (fifo_push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (out_acc) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      fifo_count <= fifo_count + FIFO_CW'(fifo_push) - FIFO_CW'(out_acc);
    end
  end

  assign out_valid = (fifo_count != '0);
  assign logit     = fifo_logit[rd_ptr];
  assign key_index = fifo_idx[rd_ptr];
  assign last_key  = fifo_last[rd_ptr];

  // Checks
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fifo_push && !out_acc |-> fifo_count != FIFO_CW'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_pending_covers_queue: assert property (@(posedge clk) disable iff (rst)
    pending >= fifo_count)
    else $error("pending count below queue occupancy");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= FIFO_CW'(FIFO_DEPTH))
    else $error("pending count beyond queue depth");

  a_result_after_row: assert property (@(posedge clk) disable iff (rst)
    in_acc && is_key && row_done |-> ##4 fifo_push)
    else $error("finished row did not reach the result queue");

endmodule

@@ rtl/akdp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module akdp_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
